// ===== src/p3ik_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_pkg
// Shared types, constants and tables of the 3-PRR inverse kinematics block.
// ----------------------------------------------------------------------------
package p3ik_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_ITERS = 16;

  localparam int LEN_W     = 24;
  localparam int ANG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_EDGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 2'd2;

  function automatic logic [LEN_W-1:0] sat24(input longint v);
    if (v > 64'hFFFFFF) return 24'hFFFFFF;
    return v[LEN_W-1:0];
  endfunction

  localparam logic [LEN_W-1:0] RST_EDGE = sat24(longint'(300) << FRAC_BITS);
  localparam logic [LEN_W-1:0] RST_LINK = sat24(longint'(50) << FRAC_BITS);
  localparam logic [LEN_W-1:0] RST_MAXR = sat24(longint'(150) << FRAC_BITS);
  localparam logic [LEN_W-1:0] RST_RUN  = sat24(longint'(75) << FRAC_BITS);

  // angles: 1/256 degree at the port, 2^-20 degree inside the CORDIC
  localparam logic [ANG_W:0]  ANG_FULL    = 18'd92160;
  localparam logic [ANG_W:0]  ANG_SIXTY   = 18'd15360;
  localparam logic signed [31:0] DEG_FULL    = 32'sd377487360;
  localparam logic signed [31:0] DEG_HALF    = 32'sd188743680;
  localparam logic signed [31:0] DEG_QUARTER = 32'sd94371840;

  localparam logic signed [33:0] SQRT3_Q30 = 34'sd1859775393;
  localparam logic signed [33:0] KGAIN_Q30 = 34'sd652032875;

  localparam int IT_W     = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam int SQ_STEPS = 28;
  localparam int CNT_MAX  = (CORDIC_ITERS > SQ_STEPS) ? CORDIC_ITERS : SQ_STEPS;
  localparam int CNT_W    = $clog2(CNT_MAX);

  function automatic logic [25:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  return 26'd47185920;
      5'd1:  return 26'd27855475;
      5'd2:  return 26'd14718068;
      5'd3:  return 26'd7471121;
      5'd4:  return 26'd3750058;
      5'd5:  return 26'd1876857;
      5'd6:  return 26'd938658;
      5'd7:  return 26'd469357;
      5'd8:  return 26'd234682;
      5'd9:  return 26'd117342;
      5'd10: return 26'd58671;
      5'd11: return 26'd29335;
      5'd12: return 26'd14668;
      5'd13: return 26'd7334;
      5'd14: return 26'd3667;
      5'd15: return 26'd1833;
      5'd16: return 26'd917;
      5'd17: return 26'd458;
      5'd18: return 26'd229;
      5'd19: return 26'd115;
      5'd20: return 26'd57;
      5'd21: return 26'd29;
      5'd22: return 26'd14;
      5'd23: return 26'd7;
      default: return 26'd0;
    endcase
  endfunction

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CINIT, OP_CSTEP, OP_MUL_LC, OP_SET_VX, OP_MUL_LS,
    OP_SET_VY, OP_MUL_SE, OP_SET_BY, OP_MUL_LINE, OP_SET_D, OP_MUL_DD,
    OP_SET_DSQ, OP_MUL_DX, OP_SET_ACC, OP_MUL_DY, OP_SET_A2, OP_MUL_LL,
    OP_SET_B2, OP_SQ_INIT, OP_SQ_STEP, OP_SQ_SAVE, OP_PICK, OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic            vtx;     // 0: vertex 1, 1: vertex 2
    logic [1:0]      leg;
    logic [IT_W-1:0] iter;
    logic            sq_sel;  // 0: projection root, 1: link root
    logic            ok;
  } dp_cmd_t;

  typedef struct packed {
    logic b2_neg;
    logic none_valid;
  } dp_stat_t;

endpackage

// ===== src/p3ik_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_in_if
// Pose channel: one word per platform pose.
// ----------------------------------------------------------------------------
interface p3ik_in_if;
  logic                valid;
  logic                ready;
  logic signed [23:0]  pos_x;
  logic signed [23:0]  pos_y;
  logic [16:0]         angle_deg;
  modport source (output valid, pos_x, pos_y, angle_deg, input ready);
  modport sink   (input valid, pos_x, pos_y, angle_deg, output ready);
endinterface

// ===== src/p3ik_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_out_if
// Run channel: one word per pose, reach flag and three slider runs.
// ----------------------------------------------------------------------------
interface p3ik_out_if;
  logic        valid;
  logic        ready;
  logic        reachable;
  logic [23:0] run_0;
  logic [23:0] run_1;
  logic [23:0] run_2;
  modport source (output valid, reachable, run_0, run_1, run_2, input ready);
  modport sink   (input valid, reachable, run_0, run_1, run_2, output ready);
endinterface

// ===== src/p3ik_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface p3ik_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [23:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== src/p3ik_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_dp
// Datapath: CORDIC, shared multiplier, iterative square root, leg selection.
// ----------------------------------------------------------------------------
module p3ik_dp (
  input  logic                clk,
  input  logic                rst,
  input  p3ik_pkg::dp_cmd_t   cmd,
  output p3ik_pkg::dp_stat_t  stat,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic [16:0]         angle_deg,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_data,
  output logic                reachable,
  output logic [23:0]         run_0,
  output logic [23:0]         run_1,
  output logic [23:0]         run_2
);
  import p3ik_pkg::*;

  logic [23:0] base_edge, link_len, max_run;
  logic [23:0] leg_run [3];
  logic [23:0] nxt [3];
  logic        reach;

  logic signed [23:0] px, py;
  logic [16:0]        ang;
  logic signed [25:0] vx [3];
  logic signed [25:0] vy [3];
  logic signed [31:0] z;
  logic signed [33:0] cx, cy;
  logic               neg;
  logic signed [63:0] p, acc;
  logic signed [25:0] by2;
  logic [27:0]        d;
  logic [55:0]        dsq, a2, b2;
  logic [55:0]        rem, root, bitm;
  logic [27:0]        ra, rb;

  // combinational helpers
  logic [16:0]        ang_w;
  logic [17:0]        ang2;
  logic [16:0]        ang_sel;
  logic signed [31:0] z0;
  logic signed [33:0] dx, dy, cs, sn;
  logic signed [31:0] at;
  logic signed [33:0] ma, mb;
  logic signed [26:0] ddx, ddy;
  logic signed [63:0] sc, vyw, nval, t_a2, t_b2;
  logic [63:0]        nabs;
  logic [55:0]        trial;
  logic signed [29:0] plus, minus, mr, rn, dp, dm;
  logic               pv, mv;
  logic [1:0]         vi;

  always_comb begin
    ang_w = (17'(angle_deg) >= ANG_FULL[16:0]) ? angle_deg - ANG_FULL[16:0] : angle_deg;
    ang2  = {1'b0, ang} + ANG_SIXTY;
    if (ang2 >= ANG_FULL) ang2 = ang2 - ANG_FULL;
    ang_sel = cmd.vtx ? ang2[16:0] : ang;
    z0 = $signed({3'b000, ang_sel, 12'b0});
    if (z0 > DEG_HALF) z0 = z0 - DEG_FULL;

    dx = cy >>> cmd.iter;
    dy = cx >>> cmd.iter;
    at = $signed({6'b0, atan_entry(5'(cmd.iter))});
    cs = neg ? -cx : cx;
    sn = neg ? -cy : cy;
    vi = cmd.vtx ? 2'd2 : 2'd1;

    case (cmd.leg)
      2'd0:    ddx = 27'(vx[0]);
      2'd1:    ddx = 27'(vx[1]) - $signed({3'b0, base_edge});
      default: ddx = 27'(vx[2]) - $signed({4'b0, base_edge[23:1]});
    endcase
    ddy = (cmd.leg == 2'd2) ? 27'(vy[2]) - 27'(by2) : 27'(vy[cmd.leg]);

    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_LC:   begin ma = $signed({10'b0, link_len}); mb = cs; end
      OP_MUL_LS:   begin ma = $signed({10'b0, link_len}); mb = sn; end
      OP_MUL_SE:   begin ma = SQRT3_Q30; mb = $signed({10'b0, base_edge}); end
      OP_MUL_LINE: begin
        ma = SQRT3_Q30;
        mb = (cmd.leg == 2'd1) ? 34'(27'(vx[1]) - $signed({3'b0, base_edge}))
                               : 34'(vx[2]);
      end
      OP_MUL_DD:   begin ma = $signed({6'b0, d}); mb = $signed({6'b0, d}); end
      OP_MUL_DX:   begin ma = 34'(ddx); mb = 34'(ddx); end
      OP_MUL_DY:   begin ma = 34'(ddy); mb = 34'(ddy); end
      OP_MUL_LL:   begin ma = $signed({10'b0, link_len}); mb = $signed({10'b0, link_len}); end
      default:     ;
    endcase

    sc   = (p + 64'sd536870912) >>> 30;
    vyw  = 64'(vy[cmd.leg]) <<< 30;
    nval = (cmd.leg == 2'd1) ? p + vyw : p - vyw;
    nabs = nval[63] ? 64'(-nval) : 64'(nval);
    t_a2 = acc + p - $signed({8'b0, dsq});
    t_b2 = p - $signed({8'b0, dsq});
    trial = root + bitm;

    plus  = $signed({2'b0, ra}) + $signed({2'b0, rb});
    minus = $signed({2'b0, ra}) - $signed({2'b0, rb});
    mr    = $signed({6'b0, max_run});
    rn    = $signed({6'b0, leg_run[cmd.leg]});
    pv    = (plus > 30'sd0) && (plus < mr);
    mv    = (minus > 30'sd0) && (minus < mr);
    dp    = plus - rn;
    dm    = minus - rn;
    if (dp < 0) dp = -dp;
    if (dm < 0) dm = -dm;
  end

  assign stat.b2_neg     = t_b2[63];
  assign stat.none_valid = !pv && !mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_edge <= RST_EDGE;
      link_len  <= RST_LINK;
      max_run   <= RST_MAXR;
      leg_run[0] <= RST_RUN;
      leg_run[1] <= RST_RUN;
      leg_run[2] <= RST_RUN;
      reach <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BASE_EDGE: base_edge <= cfg_data;
          REG_LINK_LEN:  link_len  <= cfg_data;
          REG_MAX_RUN:   max_run   <= cfg_data;
          default:       ;
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        reach <= cmd.ok;
        if (cmd.ok) begin
          leg_run[0] <= nxt[0];
          leg_run[1] <= nxt[1];
          leg_run[2] <= nxt[2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px <= pos_x;
        py <= pos_y;
        ang <= ang_w;
        vx[0] <= 26'(pos_x);
        vy[0] <= 26'(pos_y);
      end
      OP_CINIT: begin
        cx <= KGAIN_Q30;
        cy <= '0;
        if (z0 > DEG_QUARTER) begin
          z <= z0 - DEG_HALF; neg <= 1'b1;
        end else if (z0 < -DEG_QUARTER) begin
          z <= z0 + DEG_HALF; neg <= 1'b1;
        end else begin
          z <= z0; neg <= 1'b0;
        end
      end
      OP_CSTEP: begin
        if (!z[31]) begin
          cx <= cx - dx; cy <= cy + dy; z <= z - at;
        end else begin
          cx <= cx + dx; cy <= cy - dy; z <= z + at;
        end
      end
      OP_MUL_LC, OP_MUL_LS, OP_MUL_SE, OP_MUL_LINE, OP_MUL_DD, OP_MUL_DX,
      OP_MUL_DY, OP_MUL_LL: p <= 64'(ma * mb);
      OP_SET_VX:  vx[vi] <= 26'(px) + sc[25:0];
      OP_SET_VY:  vy[vi] <= 26'(py) + sc[25:0];
      OP_SET_BY:  by2 <= 26'((p + 64'sd1073741824) >>> 31);
      OP_SET_D: begin
        if (cmd.leg == 2'd0) d <= py[23] ? 28'(-$signed({py[23], py})) : 28'(py);
        else                 d <= 28'((nabs + 64'd1073741824) >> 31);
      end
      OP_SET_DSQ: dsq <= 56'(p);
      OP_SET_ACC: acc <= p;
      OP_SET_A2:  a2 <= t_a2[63] ? '0 : 56'(t_a2);
      OP_SET_B2:  b2 <= 56'(t_b2);
      OP_SQ_INIT: begin
        rem  <= cmd.sq_sel ? b2 : a2;
        root <= '0;
        bitm <= 56'd1 << 54;
      end
      OP_SQ_STEP: begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
      end
      OP_SQ_SAVE: begin
        if (cmd.sq_sel) rb <= root[27:0];
        else            ra <= root[27:0];
      end
      OP_PICK: begin
        if (pv && mv) nxt[cmd.leg] <= (dp < dm) ? plus[23:0] : minus[23:0];
        else if (pv)  nxt[cmd.leg] <= plus[23:0];
        else          nxt[cmd.leg] <= minus[23:0];
      end
      default: ;
    endcase
  end

  assign reachable = reach;
  assign run_0 = leg_run[0];
  assign run_1 = leg_run[1];
  assign run_2 = leg_run[2];

  // runs only move on a reachable commit
  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_COMMIT || !cmd.ok) |=> $stable(leg_run[0]) && $stable(leg_run[2]))
    else $error("run changed without reachable commit");
  a_sq_bit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQ_INIT) |=> $onehot(bitm))
    else $error("square root bit mask not one-hot");
  a_reach: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMMIT) |=> reach == $past(cmd.ok))
    else $error("reach flag mismatch");

endmodule

// ===== src/p3ik_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3ik_ctrl
// Sequencer: steps the datapath through both vertices and the three legs.
// ----------------------------------------------------------------------------
module p3ik_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  p3ik_pkg::dp_stat_t  stat,
  output p3ik_pkg::dp_cmd_t   cmd
);
  import p3ik_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE  = 22'd1 << 0,  S_CINIT = 22'd1 << 1,  S_CSTEP = 22'd1 << 2,
    S_MLC   = 22'd1 << 3,  S_SVX   = 22'd1 << 4,  S_MLS   = 22'd1 << 5,
    S_SVY   = 22'd1 << 6,  S_MSE   = 22'd1 << 7,  S_SBY   = 22'd1 << 8,
    S_LINE  = 22'd1 << 9,  S_SD    = 22'd1 << 10, S_MDD   = 22'd1 << 11,
    S_SDSQ  = 22'd1 << 12, S_MDX   = 22'd1 << 13, S_SACC  = 22'd1 << 14,
    S_MDY   = 22'd1 << 15, S_SA2   = 22'd1 << 16, S_MLL   = 22'd1 << 17,
    S_SB2   = 22'd1 << 18, S_SQI   = 22'd1 << 19, S_SQS   = 22'd1 << 20,
    S_FIN   = 22'd1 << 21
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             vtx, vtx_next, sq_sel, sq_sel_next, ok, ok_next, saving, saving_next;
  logic [1:0]       leg, leg_next;
  logic             pick, pick_next;
  logic             ov_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    vtx_next    = vtx;
    sq_sel_next = sq_sel;
    ok_next     = ok;
    leg_next    = leg;
    saving_next = 1'b0;
    pick_next   = 1'b0;
    ov_next     = out_valid && !out_ready;
    cmd         = '0;
    cmd.op      = OP_NOP;
    cmd.vtx     = vtx;
    cmd.leg     = leg;
    cmd.iter    = cnt[IT_W-1:0];
    cmd.sq_sel  = sq_sel;
    cmd.ok      = ok;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; vtx_next = 1'b0; leg_next = 2'd0; state_next = S_CINIT;
      end
      S_CINIT: begin cmd.op = OP_CINIT; cnt_next = '0; state_next = S_CSTEP; end
      S_CSTEP: begin
        cmd.op = OP_CSTEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_ITERS - 1)) state_next = S_MLC;
      end
      S_MLC: begin cmd.op = OP_MUL_LC; state_next = S_SVX; end
      S_SVX: begin cmd.op = OP_SET_VX; state_next = S_MLS; end
      S_MLS: begin cmd.op = OP_MUL_LS; state_next = S_SVY; end
      S_SVY: begin
        cmd.op = OP_SET_VY;
        if (!vtx) begin vtx_next = 1'b1; state_next = S_CINIT; end
        else state_next = S_MSE;
      end
      S_MSE:  begin cmd.op = OP_MUL_SE; state_next = S_SBY; end
      S_SBY:  begin cmd.op = OP_SET_BY; state_next = S_LINE; end
      S_LINE: begin
        // the pick of the previous leg shares this slot's entry
        cmd.op = OP_MUL_LINE; state_next = S_SD;
      end
      S_SD:   begin cmd.op = OP_SET_D;   state_next = S_MDD; end
      S_MDD:  begin cmd.op = OP_MUL_DD;  state_next = S_SDSQ; end
      S_SDSQ: begin cmd.op = OP_SET_DSQ; state_next = S_MDX; end
      S_MDX:  begin cmd.op = OP_MUL_DX;  state_next = S_SACC; end
      S_SACC: begin cmd.op = OP_SET_ACC; state_next = S_MDY; end
      S_MDY:  begin cmd.op = OP_MUL_DY;  state_next = S_SA2; end
      S_SA2:  begin cmd.op = OP_SET_A2;  state_next = S_MLL; end
      S_MLL:  begin cmd.op = OP_MUL_LL;  state_next = S_SB2; end
      S_SB2: begin
        cmd.op = OP_SET_B2;
        if (stat.b2_neg) begin ok_next = 1'b0; state_next = S_FIN; end
        else begin sq_sel_next = 1'b0; state_next = S_SQI; end
      end
      S_SQI: begin
        if (pick) begin
          // both roots ready: choose the candidate
          if (stat.none_valid) begin
            ok_next = 1'b0; state_next = S_FIN;
          end else begin
            cmd.op = OP_PICK;
            if (leg == 2'd2) begin ok_next = 1'b1; state_next = S_FIN; end
            else begin leg_next = leg + 1'b1; state_next = S_LINE; end
          end
        end else if (saving) begin
          cmd.op = OP_SQ_SAVE;
          if (!sq_sel) begin sq_sel_next = 1'b1; state_next = S_SQI; end
          else pick_next = 1'b1;
        end else begin
          cmd.op = OP_SQ_INIT; cnt_next = '0; state_next = S_SQS;
        end
      end
      S_SQS: begin
        cmd.op = OP_SQ_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin saving_next = 1'b1; state_next = S_SQI; end
      end
      S_FIN: if (!out_valid || out_ready) begin
        cmd.op = OP_COMMIT; ov_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; vtx <= 1'b0; sq_sel <= 1'b0; ok <= 1'b0;
      leg <= 2'd0; saving <= 1'b0; pick <= 1'b0; out_valid <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; vtx <= vtx_next; sq_sel <= sq_sel_next;
      ok <= ok_next; leg <= leg_next; saving <= saving_next; pick <= pick_next;
      out_valid <= ov_next;
    end
  end

  a_cordic_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_CSTEP) |-> (cnt < CNT_W'(CORDIC_ITERS)))
    else $error("CORDIC count overrun");
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMMIT) |-> (!out_valid || out_ready))
    else $error("commit over a pending word");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && state == S_IDLE) |=> (state == S_CINIT))
    else $error("accepted word did not start the sequence");

endmodule

// ===== src/planar_3prr_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_3prr_inverse_kinematics
// Slider runs of a planar 3-PRR manipulator from a platform pose.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  pose    | in  | pos_x, pos_y, angle_deg
//  runs    | out | reachable, run_0, run_1, run_2
//  cfg     | in  | idx, data (base_edge, link_length, max_run)
//
// One pose at a time. A reachable pose takes a load, two 16-step CORDIC passes
// and their scaling, the base vertex, then for each of the three legs two
// 28-step square roots on one shared unit, and a commit. An unreachable leg
// ends the pose early. Runs reset to 75.0, registers to their defaults; rst is
// synchronous. A pending result word does not stop the next pose being taken;
// only the commit waits for it.
module planar_3prr_inverse_kinematics (
  input logic        clk,
  input logic        rst,
  p3ik_in_if.sink    pose,
  p3ik_out_if.source runs,
  p3ik_cfg_if.sink   cfg
);
  import p3ik_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  p3ik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pose.valid),
    .in_ready  (pose.ready),
    .out_valid (runs.valid),
    .out_ready (runs.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  p3ik_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .pos_x     (pose.pos_x),
    .pos_y     (pose.pos_y),
    .angle_deg (pose.angle_deg),
    .cfg_we    (cfg.valid),
    .cfg_idx   (cfg.idx),
    .cfg_data  (cfg.data),
    .reachable (runs.reachable),
    .run_0     (runs.run_0),
    .run_1     (runs.run_1),
    .run_2     (runs.run_2)
  );

endmodule
